// ----- design/sbp_pkg.sv -----
// Package: shared types, constants and the CRC byte update for the SBP frame receiver.
`default_nettype none

package sbp_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'h55;
  localparam logic [15:0] TYPE_OBS       = 16'h004A;
  localparam logic [15:0] TYPE_EPH       = 16'h0081;
  localparam logic [15:0] TYPE_ION       = 16'h0090;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [8:0]  FRAME_OVERHEAD = 9'd8;
  localparam logic [8:0]  MAX_LEN_RESET  = 9'd263;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 8'd1;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_LEN_ERR  = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_FILTERED = 3'd3,
    ST_UNSUP    = 3'd4,
    ST_OBS      = 3'd5,
    ST_EPH      = 3'd6,
    ST_ION      = 3'd7
  } status_t;

  typedef struct packed {
    logic        frame_done;
    status_t     status;
    logic [15:0] frame_type;
    logic [15:0] sender_id;
    logic [7:0]  payload_length;
  } result_t;

  // CRC-16 CCITT, one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic status_t classify(input logic [15:0] t);
    status_t s;
    priority if (t == TYPE_OBS) begin
      s = ST_OBS;
    end else if (t == TYPE_EPH) begin
      s = ST_EPH;
    end else if (t == TYPE_ION) begin
      s = ST_ION;
    end else begin
      s = ST_UNSUP;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- design/sbp_ifs.sv -----
// Interfaces: input byte channel, result channel and configuration write channel.
`default_nettype none

interface sbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic [2:0]  status;
  logic [15:0] frame_type;
  logic [15:0] sender_id;
  logic [7:0]  payload_length;
  modport source (output valid, output frame_done, output status, output frame_type,
                  output sender_id, output payload_length, input ready);
  modport sink   (input valid, input frame_done, input status, input frame_type,
                  input sender_id, input payload_length, output ready);
endinterface

interface sbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/sbp_parser.sv -----
// Frame parser: byte position tracking, header capture, CRC and end-of-frame verdict.
`default_nettype none

module sbp_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  wire  [7:0]           rx_byte,
  input  wire                  base_mode,
  input  wire  [8:0]           max_frame_len,
  output sbp_pkg::result_t     result
);

  logic [8:0]  pos_r,    pos_nxt;
  logic [15:0] crc_r,    crc_nxt;
  logic [15:0] type_r,   type_nxt;
  logic [15:0] sender_r, sender_nxt;
  logic [7:0]  len_r,    len_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [15:0] crc_upd;
  logic [8:0]  payload_end;
  logic        keep;
  logic        done;
  sbp_pkg::status_t status;

  assign crc_upd     = sbp_pkg::crc_feed(crc_r, rx_byte);
  assign payload_end = {1'b0, len_r} + 9'd6;
  assign keep        = base_mode ? (sender_r == 16'd0) : (sender_r != 16'd0);

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    type_nxt   = type_r;
    sender_nxt = sender_r;
    len_nxt    = len_r;
    crc_lo_nxt = crc_lo_r;
    done       = 1'b0;
    status     = sbp_pkg::ST_NONE;
    priority if (pos_r == 9'd0) begin
      if (rx_byte == sbp_pkg::SYNC_BYTE) begin
        pos_nxt    = 9'd1;
        crc_nxt    = 16'd0;
        type_nxt   = 16'd0;
        sender_nxt = 16'd0;
        len_nxt    = 8'd0;
        crc_lo_nxt = 8'd0;
      end
    end else if (pos_r <= 9'd5) begin
      crc_nxt = crc_upd;
      pos_nxt = pos_r + 9'd1;
      unique case (pos_r[2:0])
        3'd1:    type_nxt   = {type_r[15:8], rx_byte};
        3'd2:    type_nxt   = {rx_byte, type_r[7:0]};
        3'd3:    sender_nxt = {sender_r[15:8], rx_byte};
        3'd4:    sender_nxt = {rx_byte, sender_r[7:0]};
        default: len_nxt    = rx_byte;
      endcase
      if (pos_r == 9'd5 && (sbp_pkg::FRAME_OVERHEAD + {1'b0, rx_byte}) > max_frame_len) begin
        done    = 1'b1;
        status  = sbp_pkg::ST_LEN_ERR;
        pos_nxt = 9'd0;
      end
    end else if (pos_r < payload_end) begin
      crc_nxt = crc_upd;
      pos_nxt = pos_r + 9'd1;
    end else if (pos_r == payload_end) begin
      crc_lo_nxt = rx_byte;
      pos_nxt    = pos_r + 9'd1;
    end else begin
      done    = 1'b1;
      pos_nxt = 9'd0;
      // sender filter wins over the CRC check
      priority if (!keep) begin
        status = sbp_pkg::ST_FILTERED;
      end else if ({rx_byte, crc_lo_r} != crc_r) begin
        status = sbp_pkg::ST_CRC_ERR;
      end else begin
        status = sbp_pkg::classify(type_r);
      end
    end
  end

  always_comb begin
    result.frame_done     = done;
    result.status         = status;
    result.frame_type     = done ? type_nxt   : 16'd0;
    result.sender_id      = done ? sender_nxt : 16'd0;
    result.payload_length = done ? len_nxt    : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 9'd0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      crc_r    <= crc_nxt;
      type_r   <= type_nxt;
      sender_r <= sender_nxt;
      len_r    <= len_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/sbp_frame_receiver.sv -----
// SBP frame receiver: takes the received byte stream one beat per byte and
// gives one result beat per byte.
//   in_ch  : one received byte per beat (rx_byte).
//   out_ch : one result per input byte; frame_done marks the byte that ends or
//            aborts a frame, status gives the verdict, with the frame header.
//   cfg_ch : register writes, index 0 base_mode, index 1 max_frame_len; always
//            ready, unknown indexes ignored. Write only while idle.
// The result of a byte is registered and appears on out_ch in the cycle after its beat.
// Throughput: one byte per cycle while out_ch does not stall; the parse, the
// CRC-16 update and the verdict are all worked out in the cycle the byte is
// accepted and land in the output register.
// When out_ch stalls the output register holds its beat and in_ch.ready drops,
// so exactly one result waits; it rises again in the cycle the result is taken.
// Reset (synchronous, rst_n low) empties the output register, puts the parser
// back to hunting for sync and restores base_mode 0 and max_frame_len 263.
`default_nettype none

module sbp_frame_receiver (
  input  wire        clk,
  input  wire        rst_n,
  sbp_in_if.sink     in_ch,
  sbp_out_if.source  out_ch,
  sbp_cfg_if.sink    cfg_ch
);

  logic              base_mode_r;
  logic [8:0]        max_len_r;
  logic              out_valid_r;
  sbp_pkg::result_t  res_r;
  sbp_pkg::result_t  res_nxt;
  logic              accept;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  sbp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .rx_byte       (in_ch.rx_byte),
    .base_mode     (base_mode_r),
    .max_frame_len (max_len_r),
    .result        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_mode_r <= 1'b0;
      max_len_r   <= sbp_pkg::MAX_LEN_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == sbp_pkg::CFG_BASE_MODE) begin
        base_mode_r <= cfg_ch.data[0];
      end else if (cfg_ch.index == sbp_pkg::CFG_MAX_LEN) begin
        max_len_r <= cfg_ch.data[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_done     = res_r.frame_done;
  assign out_ch.status         = res_r.status;
  assign out_ch.frame_type     = res_r.frame_type;
  assign out_ch.sender_id      = res_r.sender_id;
  assign out_ch.payload_length = res_r.payload_length;

endmodule

`default_nettype wire

// ----- design/sbp_checker.sv -----
// Port-level checker for the SBP frame receiver, bound to the top level.
`default_nettype none

module sbp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        frame_done,
  input wire [2:0]  status,
  input wire [15:0] frame_type,
  input wire [15:0] sender_id,
  input wire [7:0]  payload_length
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_type))
    else $error("result beat changed while stalled");

  // every accepted byte gives a result in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result one cycle after an accepted byte");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_done |->
      status == sbp_pkg::ST_NONE && frame_type == 16'd0 && sender_id == 16'd0 &&
      payload_length == 8'd0)
    else $error("non-final result carries data");

  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> status != sbp_pkg::ST_NONE)
    else $error("frame end without a verdict");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind sbp_frame_receiver sbp_checker u_sbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .frame_done     (out_ch.frame_done),
  .status         (out_ch.status),
  .frame_type     (out_ch.frame_type),
  .sender_id      (out_ch.sender_id),
  .payload_length (out_ch.payload_length)
);

`default_nettype wire
